// ===== design/msde_pkg.sv =====
package msde_pkg;

    // Instruction space is 1024 words; pc arithmetic wraps in PC_W bits.
    localparam int unsigned PC_W = 10;
    localparam int unsigned PC_WORDS = 1 << PC_W;

    // Opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SW      = 6'd43;

    // Function codes under OP_SPECIAL
    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLT     = 6'd42;

    localparam logic [4:0] LINK_REG = 5'd31;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_NOR,
        ALU_SLT,
        ALU_SLL,
        ALU_SRL,
        ALU_SRA,
        ALU_PASS
    } t_alu_op;

    typedef enum logic [2:0] {
        JK_NONE,
        JK_TGT,
        JK_REG,
        JK_BEQ,
        JK_BNE
    } t_jmp;

    typedef struct packed {
        t_alu_op    alu;
        t_jmp       jmp;
        logic [4:0] dest;
        logic [4:0] shamt;
        logic       reg_write;
        logic       mem_read;
        logic       mem_write;
        logic       syscall;
        logic       illegal;
    } t_ctrl;

endpackage

// ===== design/mips_subset_decode_execute_top.sv =====
// Decode/execute unit for an integer subset of MIPS32.
// Input channel: i_valid / o_stall carry an instruction word, its word
// address i_pc and the two source register values; a transfer happens on a
// rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one result per instruction: ALU
// value or memory address, destination register, write and memory flags,
// store data, next pc, syscall request and status.
// An instruction passes through three register stages in order: decode, ALU,
// then next-pc and status resolve. Throughput is one instruction per cycle
// while i_stall is low; each of the three stages holds one instruction.
// When i_stall holds the output, the stages behind it keep filling until
// every stage holds an instruction, then o_stall rises; nothing is dropped
// or repeated.
// Reset (i_rst_n low, synchronous) clears all stage valid bits, so o_valid
// is low and o_stall low after reset.
module mips_subset_decode_execute_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [31:0]               i_instruction,
    input  logic [msde_pkg::PC_W-1:0] i_pc,
    input  logic [31:0]               i_rs_value,
    input  logic [31:0]               i_rt_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [31:0]               o_result,
    output logic [4:0]                o_dest_reg,
    output logic                      o_reg_write,
    output logic                      o_mem_read,
    output logic                      o_mem_write,
    output logic [31:0]               o_store_data,
    output logic [msde_pkg::PC_W-1:0] o_next_pc,
    output logic                      o_syscall_request,
    output logic [1:0]                o_status
);

    localparam int unsigned PW = msde_pkg::PC_W;

    // Stage enables: a stage loads when it is empty or the one ahead loads.
    logic s1_en, s2_en, s3_en;

    // Stage 1 (decoded)
    logic                r_s1_v;
    msde_pkg::t_ctrl     r_s1_ctrl;
    logic [31:0]         r_s1_a, r_s1_b, r_s1_store;
    logic [PW-1:0]       r_s1_seq_pc, r_s1_br_pc, r_s1_jtgt;
    logic                r_s1_jfar;

    // Stage 2 (executed)
    logic                r_s2_v;
    msde_pkg::t_ctrl     r_s2_ctrl;
    logic [31:0]         r_s2_result, r_s2_store;
    logic                r_s2_eq;
    logic [PW-1:0]       r_s2_seq_pc, r_s2_br_pc, r_s2_jtgt;
    logic                r_s2_jfar;

    // Stage 3 (output)
    logic                r_valid;
    logic [31:0]         r_result, r_store_data;
    logic [4:0]          r_dest_reg;
    logic                r_reg_write, r_mem_read, r_mem_write, r_syscall;
    logic [PW-1:0]       r_next_pc;
    logic [1:0]          r_status;

    assign s3_en   = !r_valid || !i_stall;
    assign s2_en   = !r_s2_v || s3_en;
    assign s1_en   = !r_s1_v || s2_en;
    assign o_stall = !s1_en;

    // ---------------- decode ----------------
    logic [5:0]      d_op, d_fn;
    logic [15:0]     d_imm;
    logic [31:0]     d_simm;
    msde_pkg::t_ctrl n_ctrl;
    logic [31:0]     n_b;
    logic [PW-1:0]   n_jtgt;
    logic            n_jfar;

    assign d_op   = i_instruction[31:26];
    assign d_fn   = i_instruction[5:0];
    assign d_imm  = i_instruction[15:0];
    assign d_simm = {{16{d_imm[15]}}, d_imm};

    always_comb begin
        n_ctrl           = '0;
        n_ctrl.alu       = msde_pkg::ALU_PASS;
        n_ctrl.jmp       = msde_pkg::JK_NONE;
        n_ctrl.shamt     = i_instruction[10:6];
        n_b              = '0;
        if (d_op == msde_pkg::OP_SPECIAL) begin
            n_ctrl.dest      = i_instruction[15:11];
            n_ctrl.reg_write = 1'b1;
            n_b              = i_rt_value;
            case (d_fn)
                msde_pkg::FN_ADD: n_ctrl.alu = msde_pkg::ALU_ADD;
                msde_pkg::FN_SUB: n_ctrl.alu = msde_pkg::ALU_SUB;
                msde_pkg::FN_AND: n_ctrl.alu = msde_pkg::ALU_AND;
                msde_pkg::FN_OR:  n_ctrl.alu = msde_pkg::ALU_OR;
                msde_pkg::FN_XOR: n_ctrl.alu = msde_pkg::ALU_XOR;
                msde_pkg::FN_NOR: n_ctrl.alu = msde_pkg::ALU_NOR;
                msde_pkg::FN_SLT: n_ctrl.alu = msde_pkg::ALU_SLT;
                msde_pkg::FN_SLL: n_ctrl.alu = msde_pkg::ALU_SLL;
                msde_pkg::FN_SRL: n_ctrl.alu = msde_pkg::ALU_SRL;
                msde_pkg::FN_SRA: n_ctrl.alu = msde_pkg::ALU_SRA;
                msde_pkg::FN_SYSCALL: begin
                    n_ctrl.dest      = '0;
                    n_ctrl.reg_write = 1'b0;
                    n_ctrl.syscall   = 1'b1;
                    n_b              = '0;
                end
                msde_pkg::FN_JR: begin
                    n_ctrl.dest      = '0;
                    n_ctrl.reg_write = 1'b0;
                    n_ctrl.jmp       = msde_pkg::JK_REG;
                    n_b              = '0;
                end
                default: begin
                    n_ctrl.dest      = '0;
                    n_ctrl.reg_write = 1'b0;
                    n_ctrl.illegal   = 1'b1;
                    n_b              = '0;
                end
            endcase
        end else begin
            case (d_op)
                msde_pkg::OP_ADDI: begin
                    n_ctrl.alu = msde_pkg::ALU_ADD;
                    n_ctrl.dest = i_instruction[20:16];
                    n_ctrl.reg_write = 1'b1;
                    n_b = d_simm;
                end
                msde_pkg::OP_ANDI: begin
                    n_ctrl.alu = msde_pkg::ALU_AND;
                    n_ctrl.dest = i_instruction[20:16];
                    n_ctrl.reg_write = 1'b1;
                    n_b = d_simm;
                end
                msde_pkg::OP_ORI: begin
                    n_ctrl.alu = msde_pkg::ALU_OR;
                    n_ctrl.dest = i_instruction[20:16];
                    n_ctrl.reg_write = 1'b1;
                    n_b = d_simm;
                end
                msde_pkg::OP_XORI: begin
                    n_ctrl.alu = msde_pkg::ALU_XOR;
                    n_ctrl.dest = i_instruction[20:16];
                    n_ctrl.reg_write = 1'b1;
                    n_b = d_simm;
                end
                msde_pkg::OP_SLTI: begin
                    n_ctrl.alu = msde_pkg::ALU_SLT;
                    n_ctrl.dest = i_instruction[20:16];
                    n_ctrl.reg_write = 1'b1;
                    n_b = d_simm;
                end
                msde_pkg::OP_LUI: begin
                    n_ctrl.dest = i_instruction[20:16];
                    n_ctrl.reg_write = 1'b1;
                    n_b = {d_imm, 16'h0000};
                end
                msde_pkg::OP_LW: begin
                    n_ctrl.alu = msde_pkg::ALU_ADD;
                    n_ctrl.dest = i_instruction[20:16];
                    n_ctrl.reg_write = 1'b1;
                    n_ctrl.mem_read = 1'b1;
                    n_b = d_simm;
                end
                msde_pkg::OP_SW: begin
                    n_ctrl.alu = msde_pkg::ALU_ADD;
                    n_ctrl.mem_write = 1'b1;
                    n_b = d_simm;
                end
                msde_pkg::OP_BEQ: begin
                    n_ctrl.alu = msde_pkg::ALU_SUB;
                    n_ctrl.jmp = msde_pkg::JK_BEQ;
                    n_b = i_rt_value;
                end
                msde_pkg::OP_BNE: begin
                    n_ctrl.alu = msde_pkg::ALU_SUB;
                    n_ctrl.jmp = msde_pkg::JK_BNE;
                    n_b = i_rt_value;
                end
                msde_pkg::OP_J: begin
                    n_ctrl.jmp = msde_pkg::JK_TGT;
                end
                msde_pkg::OP_JAL: begin
                    n_ctrl.jmp = msde_pkg::JK_TGT;
                    n_ctrl.dest = msde_pkg::LINK_REG;
                    n_ctrl.reg_write = 1'b1;
                    n_b = 32'(i_pc) + 32'd2;
                end
                default: n_ctrl.illegal = 1'b1;
            endcase
        end
    end

    // Jump target and its range check: register for jr, field otherwise.
    always_comb begin
        if (n_ctrl.jmp == msde_pkg::JK_REG) begin
            n_jtgt = i_rs_value[PW-1:0];
            n_jfar = |i_rs_value[31:PW];
        end else begin
            n_jtgt = i_instruction[PW-1:0];
            n_jfar = |i_instruction[25:PW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_en) begin
            r_s1_v <= i_valid;
        end
        if (s1_en) begin
            r_s1_ctrl   <= n_ctrl;
            r_s1_a      <= i_rs_value;
            r_s1_b      <= n_b;
            r_s1_store  <= i_rt_value;
            r_s1_seq_pc <= i_pc + PW'(1);
            r_s1_br_pc  <= i_pc + PW'(1) + d_simm[PW-1:0];
            r_s1_jtgt   <= n_jtgt;
            r_s1_jfar   <= n_jfar;
        end
    end

    // ---------------- execute ----------------
    logic [31:0] n_result;

    always_comb begin
        case (r_s1_ctrl.alu)
            msde_pkg::ALU_ADD:  n_result = r_s1_a + r_s1_b;
            msde_pkg::ALU_SUB:  n_result = r_s1_a - r_s1_b;
            msde_pkg::ALU_AND:  n_result = r_s1_a & r_s1_b;
            msde_pkg::ALU_OR:   n_result = r_s1_a | r_s1_b;
            msde_pkg::ALU_XOR:  n_result = r_s1_a ^ r_s1_b;
            msde_pkg::ALU_NOR:  n_result = ~(r_s1_a | r_s1_b);
            msde_pkg::ALU_SLT:  n_result = {31'd0, $signed(r_s1_a) < $signed(r_s1_b)};
            msde_pkg::ALU_SLL:  n_result = r_s1_b << r_s1_ctrl.shamt;
            msde_pkg::ALU_SRL:  n_result = r_s1_b >> r_s1_ctrl.shamt;
            msde_pkg::ALU_SRA:  n_result = 32'($signed(r_s1_b) >>> r_s1_ctrl.shamt);
            default:            n_result = r_s1_b;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_en) begin
            r_s2_v <= r_s1_v;
        end
        if (s2_en) begin
            r_s2_ctrl   <= r_s1_ctrl;
            r_s2_result <= n_result;
            r_s2_eq     <= (r_s1_a == r_s1_b);
            r_s2_store  <= r_s1_store;
            r_s2_seq_pc <= r_s1_seq_pc;
            r_s2_br_pc  <= r_s1_br_pc;
            r_s2_jtgt   <= r_s1_jtgt;
            r_s2_jfar   <= r_s1_jfar;
        end
    end

    // ---------------- resolve next pc and status ----------------
    logic [PW-1:0] n_next_pc;
    logic [1:0]    n_status;
    logic          n_reg_write;

    always_comb begin
        n_next_pc   = r_s2_seq_pc;
        n_status    = r_s2_ctrl.illegal ? msde_pkg::ST_ILLEGAL : msde_pkg::ST_OK;
        n_reg_write = r_s2_ctrl.reg_write;
        case (r_s2_ctrl.jmp)
            msde_pkg::JK_TGT, msde_pkg::JK_REG: begin
                // Out-of-range target: fall through and drop the link write.
                if (r_s2_jfar) begin
                    n_status    = msde_pkg::ST_RANGE;
                    n_reg_write = 1'b0;
                end else begin
                    n_next_pc = r_s2_jtgt;
                end
            end
            msde_pkg::JK_BEQ: if (r_s2_eq) n_next_pc = r_s2_br_pc;
            msde_pkg::JK_BNE: if (!r_s2_eq) n_next_pc = r_s2_br_pc;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s3_en) begin
            r_valid <= r_s2_v;
        end
        if (s3_en) begin
            r_result     <= r_s2_result;
            r_dest_reg   <= r_s2_ctrl.dest;
            r_reg_write  <= n_reg_write;
            r_mem_read   <= r_s2_ctrl.mem_read;
            r_mem_write  <= r_s2_ctrl.mem_write;
            r_store_data <= r_s2_store;
            r_next_pc    <= n_next_pc;
            r_syscall    <= r_s2_ctrl.syscall;
            r_status     <= n_status;
        end
    end

    assign o_valid           = r_valid;
    assign o_result          = r_result;
    assign o_dest_reg        = r_dest_reg;
    assign o_reg_write       = r_reg_write;
    assign o_mem_read        = r_mem_read;
    assign o_mem_write       = r_mem_write;
    assign o_store_data      = r_store_data;
    assign o_next_pc         = r_next_pc;
    assign o_syscall_request = r_syscall;
    assign o_status          = r_status;

endmodule

// ===== design/msde_checker.sv =====
module msde_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [31:0]               o_result,
    input logic [4:0]                o_dest_reg,
    input logic                      o_reg_write,
    input logic                      o_mem_read,
    input logic                      o_mem_write,
    input logic [msde_pkg::PC_W-1:0] o_next_pc,
    input logic [1:0]                o_status
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result) && $stable(o_next_pc)
            && $stable(o_status) && $stable(o_dest_reg))
        else $error("stalled output transfer changed");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // An illegal instruction writes nothing and reports a zero result.
    a_illegal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == msde_pkg::ST_ILLEGAL |->
            !o_reg_write && !o_mem_read && !o_mem_write && o_result == 32'd0)
        else $error("illegal instruction has side effects");

    // A jump out of range never writes a register.
    a_range_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == msde_pkg::ST_RANGE |-> !o_reg_write)
        else $error("out-of-range jump writes a register");

    // A load always writes its destination and is never flagged.
    a_load_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mem_read |-> o_reg_write && !o_mem_write
            && o_status == msde_pkg::ST_OK)
        else $error("load without register write");

endmodule

bind mips_subset_decode_execute_top msde_checker u_msde_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_result    (o_result),
    .o_dest_reg  (o_dest_reg),
    .o_reg_write (o_reg_write),
    .o_mem_read  (o_mem_read),
    .o_mem_write (o_mem_write),
    .o_next_pc   (o_next_pc),
    .o_status    (o_status)
);

// ===== tb/msde_result_checker.sv =====
module msde_result_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [31:0]               i_instruction,
    input  logic [msde_pkg::PC_W-1:0] i_pc,
    input  logic [31:0]               i_rs_value,
    input  logic [31:0]               i_rt_value,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [31:0]               i_result,
    input  logic [4:0]                i_dest_reg,
    input  logic                      i_reg_write,
    input  logic                      i_mem_read,
    input  logic                      i_mem_write,
    input  logic [31:0]               i_store_data,
    input  logic [msde_pkg::PC_W-1:0] i_next_pc,
    input  logic                      i_syscall_request,
    input  logic [1:0]                i_status,
    output int                        o_fail_count,
    output int                        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0]               result;
        logic [4:0]                dest_reg;
        logic                      reg_write;
        logic                      mem_read;
        logic                      mem_write;
        logic [31:0]               store_data;
        logic [msde_pkg::PC_W-1:0] next_pc;
        logic                      syscall_request;
        logic [1:0]                status;
    } t_exec_result;

    t_exec_result pending_results[$];
    int fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic t_exec_result execute_insn(logic [31:0] insn,
                                                  logic [msde_pkg::PC_W-1:0] pc,
                                                  logic [31:0] a, logic [31:0] b);
        t_exec_result r;
        logic [5:0]   op;
        logic [5:0]   fn;
        logic [4:0]   rt;
        logic [4:0]   rd;
        logic [4:0]   sh;
        logic [31:0]  simm;
        logic [31:0]  branch_sum;
        logic [31:0]  jump_target;
        logic         jump;

        op = insn[31:26];
        rt = insn[20:16];
        rd = insn[15:11];
        sh = insn[10:6];
        fn = insn[5:0];
        simm = {{16{insn[15]}}, insn[15:0]};
        jump = 1'b0;
        jump_target = '0;

        r = '0;
        r.store_data = b;
        r.next_pc = pc + 1'b1;
        r.status = msde_pkg::ST_OK;

        if (op == msde_pkg::OP_SPECIAL) begin
            r.dest_reg = rd;
            r.reg_write = 1'b1;
            case (fn)
                msde_pkg::FN_ADD: r.result = a + b;
                msde_pkg::FN_SUB: r.result = a - b;
                msde_pkg::FN_AND: r.result = a & b;
                msde_pkg::FN_OR:  r.result = a | b;
                msde_pkg::FN_XOR: r.result = a ^ b;
                msde_pkg::FN_NOR: r.result = ~(a | b);
                msde_pkg::FN_SLT: r.result = 32'($signed(a) < $signed(b));
                msde_pkg::FN_SLL: r.result = b << sh;
                msde_pkg::FN_SRL: r.result = b >> sh;
                msde_pkg::FN_SRA: r.result = $signed(b) >>> sh;
                msde_pkg::FN_SYSCALL: begin
                    r.dest_reg = '0;
                    r.reg_write = 1'b0;
                    r.syscall_request = 1'b1;
                end
                msde_pkg::FN_JR: begin
                    r.dest_reg = '0;
                    r.reg_write = 1'b0;
                    jump = 1'b1;
                    jump_target = a;
                end
                default: begin
                    r.dest_reg = '0;
                    r.reg_write = 1'b0;
                    r.status = msde_pkg::ST_ILLEGAL;
                end
            endcase
        end else begin
            case (op)
                msde_pkg::OP_ADDI: begin
                    r.result = a + simm;
                    r.dest_reg = rt;
                    r.reg_write = 1'b1;
                end
                msde_pkg::OP_ANDI: begin
                    r.result = a & simm;
                    r.dest_reg = rt;
                    r.reg_write = 1'b1;
                end
                msde_pkg::OP_ORI: begin
                    r.result = a | simm;
                    r.dest_reg = rt;
                    r.reg_write = 1'b1;
                end
                msde_pkg::OP_XORI: begin
                    r.result = a ^ simm;
                    r.dest_reg = rt;
                    r.reg_write = 1'b1;
                end
                msde_pkg::OP_SLTI: begin
                    r.result = 32'($signed(a) < $signed(simm));
                    r.dest_reg = rt;
                    r.reg_write = 1'b1;
                end
                msde_pkg::OP_LUI: begin
                    r.result = {insn[15:0], 16'h0000};
                    r.dest_reg = rt;
                    r.reg_write = 1'b1;
                end
                msde_pkg::OP_LW: begin
                    r.result = a + simm;
                    r.dest_reg = rt;
                    r.reg_write = 1'b1;
                    r.mem_read = 1'b1;
                end
                msde_pkg::OP_SW: begin
                    r.result = a + simm;
                    r.mem_write = 1'b1;
                end
                msde_pkg::OP_BEQ, msde_pkg::OP_BNE: begin
                    r.result = a - b;
                    // instruction space is a power of two, so the low bits are the residue
                    if ((op == msde_pkg::OP_BEQ) == (a == b)) begin
                        branch_sum = 32'(pc) + 32'd1 + simm;
                        r.next_pc = branch_sum[msde_pkg::PC_W-1:0];
                    end
                end
                msde_pkg::OP_J: begin
                    jump = 1'b1;
                    jump_target = {6'b0, insn[25:0]};
                end
                msde_pkg::OP_JAL: begin
                    jump = 1'b1;
                    jump_target = {6'b0, insn[25:0]};
                    r.result = 32'(pc) + 32'd2;
                    r.dest_reg = msde_pkg::LINK_REG;
                    r.reg_write = 1'b1;
                end
                default: r.status = msde_pkg::ST_ILLEGAL;
            endcase
        end

        if (jump) begin
            if (jump_target < msde_pkg::PC_WORDS) begin
                r.next_pc = jump_target[msde_pkg::PC_W-1:0];
            end else begin
                // out of range: keep sequential flow, drop the link write
                r.status = msde_pkg::ST_RANGE;
                r.reg_write = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_exec_result want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(execute_insn(i_instruction, i_pc,
                                                       i_rs_value, i_rt_value));
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no instruction outstanding");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("result", want.result, i_result);
                    check_field("dest_reg", 32'(want.dest_reg), 32'(i_dest_reg));
                    check_field("reg_write", 32'(want.reg_write), 32'(i_reg_write));
                    check_field("mem_read", 32'(want.mem_read), 32'(i_mem_read));
                    check_field("mem_write", 32'(want.mem_write), 32'(i_mem_write));
                    check_field("store_data", want.store_data, i_store_data);
                    check_field("next_pc", 32'(want.next_pc), 32'(i_next_pc));
                    check_field("syscall_request", 32'(want.syscall_request),
                                32'(i_syscall_request));
                    check_field("status", 32'(want.status), 32'(i_status));
                end
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [5:0] ILLEGAL_OP = 6'd63;
    localparam logic [5:0] ILLEGAL_FN = 6'd1;
    localparam int RANDOM_ITEMS = 1100;
    localparam int unsigned PW = msde_pkg::PC_W;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    logic [31:0]     i_instruction;
    logic [PW-1:0]   i_pc;
    logic [31:0]     i_rs_value;
    logic [31:0]     i_rt_value;
    logic            o_valid;
    logic            i_stall;
    logic [31:0]     o_result;
    logic [4:0]      o_dest_reg;
    logic            o_reg_write;
    logic            o_mem_read;
    logic            o_mem_write;
    logic [31:0]     o_store_data;
    logic [PW-1:0]   o_next_pc;
    logic            o_syscall_request;
    logic [1:0]      o_status;

    int fail_count;
    int outstanding;
    int calm_left = 0;

    always #6 i_clk = ~i_clk;

    mips_subset_decode_execute_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_instruction     (i_instruction),
        .i_pc              (i_pc),
        .i_rs_value        (i_rs_value),
        .i_rt_value        (i_rt_value),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_result          (o_result),
        .o_dest_reg        (o_dest_reg),
        .o_reg_write       (o_reg_write),
        .o_mem_read        (o_mem_read),
        .o_mem_write       (o_mem_write),
        .o_store_data      (o_store_data),
        .o_next_pc         (o_next_pc),
        .o_syscall_request (o_syscall_request),
        .o_status          (o_status)
    );

    msde_result_checker result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_instruction     (i_instruction),
        .i_pc              (i_pc),
        .i_rs_value        (i_rs_value),
        .i_rt_value        (i_rt_value),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_result          (o_result),
        .i_dest_reg        (o_dest_reg),
        .i_reg_write       (o_reg_write),
        .i_mem_read        (o_mem_read),
        .i_mem_write       (o_mem_write),
        .i_store_data      (o_store_data),
        .i_next_pc         (o_next_pc),
        .i_syscall_request (o_syscall_request),
        .i_status          (o_status),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding)
    );

    function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                           logic [4:0] rd, logic [4:0] sh);
        return {msde_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] j_word(logic [5:0] op, logic [25:0] tgt);
        return {op, tgt};
    endfunction

    // Mostly legal opcodes over random fields, a few raw words as noise.
    function automatic logic [31:0] random_insn();
        logic [31:0] w;
        int          k;
        w = $urandom;
        if ($urandom_range(0, 99) < 8) return w;
        k = $urandom_range(0, 23);
        if (k < 12) w[31:26] = msde_pkg::OP_SPECIAL;
        case (k)
            0:  w[5:0] = msde_pkg::FN_ADD;
            1:  w[5:0] = msde_pkg::FN_SUB;
            2:  w[5:0] = msde_pkg::FN_AND;
            3:  w[5:0] = msde_pkg::FN_OR;
            4:  w[5:0] = msde_pkg::FN_XOR;
            5:  w[5:0] = msde_pkg::FN_NOR;
            6:  w[5:0] = msde_pkg::FN_SLT;
            7:  w[5:0] = msde_pkg::FN_SLL;
            8:  w[5:0] = msde_pkg::FN_SRL;
            9:  w[5:0] = msde_pkg::FN_SRA;
            10: w[5:0] = msde_pkg::FN_SYSCALL;
            11: w[5:0] = msde_pkg::FN_JR;
            12: w[31:26] = msde_pkg::OP_ADDI;
            13: w[31:26] = msde_pkg::OP_ANDI;
            14: w[31:26] = msde_pkg::OP_ORI;
            15: w[31:26] = msde_pkg::OP_XORI;
            16: w[31:26] = msde_pkg::OP_SLTI;
            17: w[31:26] = msde_pkg::OP_LUI;
            18: w[31:26] = msde_pkg::OP_LW;
            19: w[31:26] = msde_pkg::OP_SW;
            20: w[31:26] = msde_pkg::OP_BEQ;
            21: w[31:26] = msde_pkg::OP_BNE;
            22: w[31:26] = msde_pkg::OP_J;
            default: w[31:26] = msde_pkg::OP_JAL;
        endcase
        // keep half of the jump targets inside the instruction space
        if (k >= 22 && $urandom_range(0, 1) == 1)
            w[25:0] = 26'($urandom_range(0, msde_pkg::PC_WORDS - 1));
        return w;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 11))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Drive one instruction, hold it until the transfer, then maybe leave a gap.
    task automatic send_insn(logic [31:0] insn, logic [PW-1:0] pc,
                             logic [31:0] a, logic [31:0] b);
        logic took;
        int   gap;
        int   pick;
        i_valid       <= 1'b1;
        i_instruction <= insn;
        i_pc          <= pc;
        i_rs_value    <= a;
        i_rt_value    <= b;
        // stall settles by the falling edge and holds until the next rising one
        do begin
            @(negedge i_clk);
            took = !o_stall;
            @(posedge i_clk);
        end while (!took);

        gap = 0;
        if (calm_left > 0) begin
            calm_left--;
        end else if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(20, 60);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick >= 92) gap = $urandom_range(8, 40);
            else if (pick >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin : stall_pattern
        int len;
        i_stall = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 3);
                i_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin : stimulus
        logic [31:0]     insn;
        logic [31:0]     a;
        logic [31:0]     b;
        logic [PW-1:0]   pc;
        int              guard;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_instruction = '0;
        i_pc          = '0;
        i_rs_value    = '0;
        i_rt_value    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every operation at least once, at the corners of its operands
        send_insn(r_word(msde_pkg::FN_ADD, 5'd1, 5'd2, 5'd31, 5'd0), 10'd0,
                  32'h7FFF_FFFF, 32'h1);
        send_insn(r_word(msde_pkg::FN_SUB, 5'd31, 5'd30, 5'd0, 5'd0), 10'd1, 32'h0, 32'h1);
        send_insn(r_word(msde_pkg::FN_AND, 5'd3, 5'd4, 5'd5, 5'd0), 10'd2, 32'hFFFF_FFFF,
                  32'hA5A5_5A5A);
        send_insn(r_word(msde_pkg::FN_OR, 5'd6, 5'd7, 5'd8, 5'd0), 10'd3, 32'h0,
                  32'h8000_0001);
        send_insn(r_word(msde_pkg::FN_XOR, 5'd9, 5'd10, 5'd11, 5'd0), 10'd4, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_insn(r_word(msde_pkg::FN_NOR, 5'd0, 5'd0, 5'd12, 5'd0), 10'd5, 32'h0, 32'h0);
        send_insn(r_word(msde_pkg::FN_SLT, 5'd13, 5'd14, 5'd15, 5'd0), 10'd6, 32'h8000_0000,
                  32'h7FFF_FFFF);
        send_insn(r_word(msde_pkg::FN_SLL, 5'd0, 5'd16, 5'd17, 5'd31), 10'd7,
                  32'hFFFF_FFFF, 32'h1);
        send_insn(r_word(msde_pkg::FN_SRL, 5'd0, 5'd18, 5'd19, 5'd31), 10'd8, 32'h0,
                  32'h8000_0000);
        send_insn(r_word(msde_pkg::FN_SRA, 5'd0, 5'd20, 5'd21, 5'd31), 10'd9, 32'h0,
                  32'h8000_0000);
        send_insn(r_word(msde_pkg::FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0), 10'd10, 32'h1234,
                  32'h5678);
        send_insn(r_word(msde_pkg::FN_JR, 5'd31, 5'd0, 5'd0, 5'd0), 10'd11, 32'd1023,
                  32'h0);
        send_insn(r_word(msde_pkg::FN_JR, 5'd31, 5'd0, 5'd0, 5'd0), 10'd12, 32'd1024,
                  32'h0);
        send_insn(r_word(ILLEGAL_FN, 5'd1, 5'd2, 5'd3, 5'd4), 10'd13, 32'h1, 32'h2);
        send_insn(i_word(msde_pkg::OP_ADDI, 5'd1, 5'd2, 16'h8000), 10'd14, 32'h0, 32'h0);
        send_insn(i_word(msde_pkg::OP_ANDI, 5'd3, 5'd4, 16'hFFFF), 10'd15, 32'h1234_5678,
                  32'h0);
        send_insn(i_word(msde_pkg::OP_ORI, 5'd5, 5'd6, 16'h8001), 10'd16, 32'h0, 32'h0);
        send_insn(i_word(msde_pkg::OP_XORI, 5'd7, 5'd8, 16'h7FFF), 10'd17, 32'hFFFF_FFFF,
                  32'h0);
        send_insn(i_word(msde_pkg::OP_SLTI, 5'd9, 5'd10, 16'hFFFF), 10'd18, 32'h8000_0000,
                  32'h0);
        send_insn(i_word(msde_pkg::OP_LUI, 5'd0, 5'd31, 16'hFFFF), 10'd19, 32'h0, 32'h0);
        send_insn(i_word(msde_pkg::OP_LW, 5'd11, 5'd12, 16'hFFFC), 10'd20, 32'h0, 32'h0);
        send_insn(i_word(msde_pkg::OP_SW, 5'd13, 5'd14, 16'h0001), 10'd21, 32'hFFFF_FFFF,
                  32'hDEAD_BEEF);
        // branch back past address zero, then forward past the top
        send_insn(i_word(msde_pkg::OP_BEQ, 5'd1, 5'd2, 16'hFFFB), 10'd0, 32'h55, 32'h55);
        send_insn(i_word(msde_pkg::OP_BNE, 5'd1, 5'd2, 16'h0000), 10'd1023, 32'h1, 32'h2);
        send_insn(i_word(msde_pkg::OP_BEQ, 5'd1, 5'd2, 16'h7FFF), 10'd1023, 32'h1, 32'h2);
        send_insn(j_word(msde_pkg::OP_J, 26'd1023), 10'd1023, 32'h0, 32'h0);
        send_insn(j_word(msde_pkg::OP_J, 26'h3FF_FFFF), 10'd22, 32'h0, 32'h0);
        send_insn(j_word(msde_pkg::OP_JAL, 26'd0), 10'd1023, 32'h0, 32'h0);
        send_insn(j_word(msde_pkg::OP_JAL, 26'd1024), 10'd23, 32'h0, 32'h0);
        send_insn(j_word(ILLEGAL_OP, 26'h155_5555), 10'd24, 32'h0, 32'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            insn = random_insn();
            a = random_operand();
            b = random_operand();
            if (insn[31:26] == msde_pkg::OP_SPECIAL && insn[5:0] == msde_pkg::FN_JR
                && $urandom_range(0, 1) == 1)
                a = $urandom_range(0, msde_pkg::PC_WORDS - 1);
            if ((insn[31:26] == msde_pkg::OP_BEQ || insn[31:26] == msde_pkg::OP_BNE)
                && $urandom_range(0, 1) == 1)
                b = a;
            case ($urandom_range(0, 19))
                0:       pc = '0;
                1:       pc = PW'(msde_pkg::PC_WORDS - 1);
                default: pc = PW'($urandom_range(0, msde_pkg::PC_WORDS - 1));
            endcase
            send_insn(insn, pc, a, b);
        end
        i_valid <= 1'b0;

        guard = 0;
        while (outstanding != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (outstanding != 0) $error("%0d results never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
